[hw/rtl/wavp_pkg.sv]
// Shared types and constants for the RIFF/WAVE header stream parser.
package wavp_pkg;

  // Chunk tags as little-endian 32-bit words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Fixed part of the fmt chunk body
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  // Accepted format values
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] MAX_CHANNELS = 16'd2;
  localparam logic [31:0] RATE_11025   = 32'd11025;
  localparam logic [31:0] RATE_22050   = 32'd22050;
  localparam logic [31:0] RATE_44100   = 32'd44100;
  localparam logic [31:0] RATE_48000   = 32'd48000;
  localparam logic [15:0] BITS_8       = 16'd8;
  localparam logic [15:0] BITS_16      = 16'd16;
  localparam logic [15:0] BITS_24      = 16'd24;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_PCM    = 2'd2
  } status_e;

  // Parser phases, one-hot
  typedef enum logic [12:0] {
    PH_RIFF    = 13'b0_0000_0000_0001,
    PH_RLEN    = 13'b0_0000_0000_0010,
    PH_WAVE    = 13'b0_0000_0000_0100,
    PH_FMTID   = 13'b0_0000_0000_1000,
    PH_FMTSZ   = 13'b0_0000_0001_0000,
    PH_FMTBODY = 13'b0_0000_0010_0000,
    PH_FMTEXT  = 13'b0_0000_0100_0000,
    PH_CKID    = 13'b0_0000_1000_0000,
    PH_DATASZ  = 13'b0_0001_0000_0000,
    PH_CKSZ    = 13'b0_0010_0000_0000,
    PH_CKSKIP  = 13'b0_0100_0000_0000,
    PH_PCM     = 13'b0_1000_0000_0000,
    PH_REJECT  = 13'b1_0000_0000_0000
  } phase_e;

endpackage

[hw/rtl/wavp_if.sv]
// Valid/ready stream interfaces for the parser input and result channels.
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] file_byte;

  modport source (output valid, kind, file_byte, input ready);
  modport sink   (input valid, kind, file_byte, output ready);
endinterface

interface wavp_out_if;
  logic              valid;
  logic              ready;
  wavp_pkg::status_e status;
  logic [7:0]        pcm_byte;
  logic [1:0]        channel_count;
  logic [15:0]       sample_rate;
  logic [4:0]        sample_bits;
  logic [31:0]       data_length;

  modport source (output valid, status, pcm_byte, channel_count, sample_rate, sample_bits,
                  data_length, input ready);
  modport sink   (input valid, status, pcm_byte, channel_count, sample_rate, sample_bits,
                  data_length, output ready);
endinterface

[hw/rtl/wav_header_stream_parser.sv]
// RIFF/WAVE header stream parser top level.
//
// Usage: feed a WAVE file one byte per item on in_i (kind 0 = file byte,
// kind 1 = end of stream). The parser checks the RIFF and WAVE tags, reads
// the fmt chunk, skips other chunks until the data chunk header, and then
// passes every further byte through as PCM on out_o. It gives one result
// when the header is accepted (format and data length), one when the file
// is rejected, and one per PCM byte. After a rejection bytes are dropped
// until end of stream; end of stream always rearms the parser for a new file.
// Output: a result shows on out_o in the cycle after its item is accepted.
// Throughput: one item per cycle while out_o is not stalled; each byte updates
// the parser state and the result lands in one output register.
// Reset: the parser expects a RIFF tag and the output register is empty.
// Stall: while out_o holds an item that is not taken, in_i.ready is low and
// the held item stays unchanged; an item is taken in the same cycle in which
// the held result leaves.
module wav_header_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  wavp_in_if.sink             in_i,
  wavp_out_if.source          out_o
);
  import wavp_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pcm_byte;
    logic [1:0]  channel_count;
    logic [15:0] sample_rate;
    logic [4:0]  sample_bits;
    logic [31:0] data_length;
  } res_t;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] ws_q, ws_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] chunk_q, chunk_d;
  logic [15:0] fmt_tag_q, fmt_tag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        pad_q, pad_d;

  // Output register
  logic        out_valid_q;
  res_t        res_q;

  // Step logic
  logic        accept;
  logic        res_valid;
  res_t        res;
  logic [31:0] ws_next;
  logic [1:0]  cnt_next;
  logic [3:0]  body_idx;
  logic [31:0] ext_len;
  logic        busy;
  logic        fmt_good;

  function automatic logic format_ok(logic [15:0] tag, logic [15:0] chan,
                                     logic [31:0] rate, logic [15:0] bits);
    logic ok;
    ok = (tag == FMT_PCM) && (chan <= MAX_CHANNELS);
    ok = ok && (rate == RATE_11025 || rate == RATE_22050 ||
                rate == RATE_44100 || rate == RATE_48000);
    ok = ok && (bits == BITS_8 || bits == BITS_16 || bits == BITS_24);
    return ok;
  endfunction

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign ws_next    = {in_i.file_byte, ws_q[31:8]};
  assign cnt_next   = cnt_q + 2'd1;
  assign body_idx   = 4'd0 - skip_q[3:0];
  assign ext_len    = chunk_q - FMT_BODY_LEN;
  assign busy       = (phase_q == PH_RIFF)   || (phase_q == PH_RLEN)  ||
                      (phase_q == PH_WAVE)   || (phase_q == PH_FMTID) ||
                      (phase_q == PH_FMTSZ)  || (phase_q == PH_FMTBODY) ||
                      (phase_q == PH_FMTEXT) || (phase_q == PH_CKID)  ||
                      (phase_q == PH_DATASZ) || (phase_q == PH_CKSZ)  ||
                      (phase_q == PH_CKSKIP);

  // Advance the parser by one accepted item
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    ws_d      = ws_q;
    skip_d    = skip_q;
    chunk_d   = chunk_q;
    fmt_tag_d = fmt_tag_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    pad_d     = pad_q;
    res_valid = 1'b0;
    res       = '0;
    fmt_good  = 1'b0;

    if (accept) begin
      if (in_i.kind) begin
        // End of stream: rearm, report an unfinished header as rejected
        phase_d   = PH_RIFF;
        cnt_d     = '0;
        ws_d      = '0;
        skip_d    = '0;
        chunk_d   = '0;
        fmt_tag_d = '0;
        chan_d    = '0;
        rate_d    = '0;
        bits_d    = '0;
        pad_d     = 1'b0;
        if (busy) begin
          res_valid  = 1'b1;
          res.status = ST_REJECT;
        end
      end else begin
        case (phase_q)
          PH_PCM: begin
            res_valid    = 1'b1;
            res.status   = ST_PCM;
            res.pcm_byte = in_i.file_byte;
          end
          PH_FMTBODY: begin
            // Capture format fields by byte position in the body
            if (body_idx < 4'd2) begin
              fmt_tag_d[{body_idx[0], 3'b000} +: 8] = in_i.file_byte;
            end else if (body_idx < 4'd4) begin
              chan_d[{body_idx[0], 3'b000} +: 8] = in_i.file_byte;
            end else if (body_idx < 4'd8) begin
              rate_d[{body_idx[1:0], 3'b000} +: 8] = in_i.file_byte;
            end else if (body_idx >= 4'd14) begin
              bits_d[{body_idx[0], 3'b000} +: 8] = in_i.file_byte;
            end
            if (skip_q != '0) begin
              skip_d = skip_q - 32'd1;
            end
            if (skip_d == '0) begin
              skip_d = ext_len;
              pad_d  = ext_len[0];
              if (ext_len == '0) begin
                fmt_good = format_ok(fmt_tag_d, chan_d, rate_d, bits_d);
                if (fmt_good) begin
                  phase_d = PH_CKID;
                end else begin
                  phase_d    = PH_REJECT;
                  res_valid  = 1'b1;
                  res.status = ST_REJECT;
                end
              end else begin
                phase_d = PH_FMTEXT;
              end
            end
          end
          PH_FMTEXT, PH_CKSKIP: begin
            // Drop one skipped byte, then the pad byte of an odd length
            if (skip_q != '0) begin
              skip_d = skip_q - 32'd1;
            end else begin
              pad_d = 1'b0;
            end
            if (skip_d == '0 && !pad_d) begin
              if (phase_q == PH_CKSKIP) begin
                phase_d = PH_CKID;
              end else begin
                fmt_good = format_ok(fmt_tag_q, chan_q, rate_q, bits_q);
                if (fmt_good) begin
                  phase_d = PH_CKID;
                end else begin
                  phase_d    = PH_REJECT;
                  res_valid  = 1'b1;
                  res.status = ST_REJECT;
                end
              end
            end
          end
          PH_RIFF, PH_RLEN, PH_WAVE, PH_FMTID, PH_FMTSZ, PH_CKID, PH_DATASZ,
          PH_CKSZ: begin
            // Shift in a header word, act on it once four bytes are in
            ws_d  = ws_next;
            cnt_d = cnt_next;
            if (cnt_next == 2'd0) begin
              case (phase_q)
                PH_RIFF: begin
                  if (ws_next != TAG_RIFF) begin
                    phase_d    = PH_REJECT;
                    res_valid  = 1'b1;
                    res.status = ST_REJECT;
                  end else begin
                    phase_d = PH_RLEN;
                  end
                end
                PH_RLEN: begin
                  if (ws_next == '0) begin
                    phase_d    = PH_REJECT;
                    res_valid  = 1'b1;
                    res.status = ST_REJECT;
                  end else begin
                    phase_d = PH_WAVE;
                  end
                end
                PH_WAVE: begin
                  if (ws_next != TAG_WAVE) begin
                    phase_d    = PH_REJECT;
                    res_valid  = 1'b1;
                    res.status = ST_REJECT;
                  end else begin
                    phase_d = PH_FMTID;
                  end
                end
                PH_FMTID: begin
                  if (ws_next != TAG_FMT) begin
                    phase_d    = PH_REJECT;
                    res_valid  = 1'b1;
                    res.status = ST_REJECT;
                  end else begin
                    phase_d = PH_FMTSZ;
                  end
                end
                PH_FMTSZ: begin
                  if (ws_next < FMT_BODY_LEN) begin
                    phase_d    = PH_REJECT;
                    res_valid  = 1'b1;
                    res.status = ST_REJECT;
                  end else begin
                    chunk_d   = ws_next;
                    skip_d    = FMT_BODY_LEN;
                    fmt_tag_d = '0;
                    chan_d    = '0;
                    rate_d    = '0;
                    bits_d    = '0;
                    phase_d   = PH_FMTBODY;
                  end
                end
                PH_CKID: begin
                  phase_d = (ws_next == TAG_DATA) ? PH_DATASZ : PH_CKSZ;
                end
                PH_DATASZ: begin
                  phase_d           = PH_PCM;
                  res_valid         = 1'b1;
                  res.status        = ST_ACCEPT;
                  res.channel_count = chan_q[1:0];
                  res.sample_rate   = rate_q[15:0];
                  res.sample_bits   = bits_q[4:0];
                  res.data_length   = ws_next;
                end
                PH_CKSZ: begin
                  skip_d  = ws_next;
                  pad_d   = ws_next[0];
                  phase_d = (ws_next == '0) ? PH_CKID : PH_CKSKIP;
                end
                default: begin
                end
              endcase
            end
          end
          default: begin
            // Rejected file or unused code: drop the byte
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RIFF;
      cnt_q     <= '0;
      ws_q      <= '0;
      skip_q    <= '0;
      chunk_q   <= '0;
      fmt_tag_q <= '0;
      chan_q    <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      pad_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      ws_q      <= ws_d;
      skip_q    <= skip_d;
      chunk_q   <= chunk_d;
      fmt_tag_q <= fmt_tag_d;
      chan_q    <= chan_d;
      rate_q    <= rate_d;
      bits_q    <= bits_d;
      pad_q     <= pad_d;
    end
  end

  // Load the output register, clear it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.pcm_byte      = res_q.pcm_byte;
  assign out_o.channel_count = res_q.channel_count;
  assign out_o.sample_rate   = res_q.sample_rate;
  assign out_o.sample_bits   = res_q.sample_bits;
  assign out_o.data_length   = res_q.data_length;

`ifndef SYNTHESIS
  // End of stream always rearms the parser
  a_eos_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.kind) |=> (phase_q == PH_RIFF))
    else $error("parser not rearmed after end of stream");

  // A byte in pass-through comes out unchanged in the next cycle
  a_pcm_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.kind && phase_q == PH_PCM) |=>
      (out_valid_q && res_q.status == ST_PCM && res_q.pcm_byte == $past(in_i.file_byte)))
    else $error("pcm byte not passed through");

  // A rejected file yields nothing for its remaining bytes
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.kind && phase_q == PH_REJECT) |=> !out_valid_q)
    else $error("result produced after rejection");
`endif

endmodule
